// ===== hdl/pdt_pkg.sv =====
package pdt_pkg;

	localparam int DEF_SLOTS = 4;
	localparam int REG_SLOTS = 4;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_REPORT  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [2:0] CFG_ENABLE  = 3'd0;
	localparam logic [2:0] CFG_INTV_LO = 3'd1;
	localparam logic [2:0] CFG_INTV_HI = 3'd2;
	localparam logic [2:0] CFG_BUD_LO  = 3'd3;
	localparam logic [2:0] CFG_BUD_HI  = 3'd4;

	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_ACK      = 1'b1;

	typedef struct packed {
		logic load;
		logic tick_setup;
		logic scan_next;
		logic restart;
		logic emit_dispatch;
		logic emit_report;
	} pdt_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       due_now;
		logic       last_idx;
	} pdt_stat_t;

endpackage

// ===== hdl/periodic_task_dispatcher_top.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    cmd, now_ms, slot, runtime_us
// out      output     out_valid/out_ready  kind, task_slot, elapsed_ms, loop_number,
//                                          total_runs, overran, slot_runs,
//                                          slot_overruns, total_overruns, last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time: accept, decode, then a tick scans its slots in order
// (min(SLOTS,4) slots), a report emits one result, a restart emits none
// a due slot or report waits while the output register holds an untaken result
// the next item is accepted while the last result still waits in the output register
// reset clears config registers, counters, last-run times, scan state and the output valid
module periodic_task_dispatcher_top import pdt_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [1:0]  slot,
	input  logic [31:0] runtime_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [1:0]  task_slot,
	output logic [31:0] elapsed_ms,
	output logic [31:0] loop_number,
	output logic [31:0] total_runs,
	output logic        overran,
	output logic [31:0] slot_runs,
	output logic [31:0] slot_overruns,
	output logic [31:0] total_overruns,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	pdt_ctl_t  ctl;
	pdt_stat_t stat;

	assign cfg_ready = 1'b1;

	pdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.ctl       (ctl)
	);

	pdt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.now_ms         (now_ms),
		.slot           (slot),
		.runtime_us     (runtime_us),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.ctl            (ctl),
		.stat           (stat),
		.kind           (kind),
		.task_slot      (task_slot),
		.elapsed_ms     (elapsed_ms),
		.loop_number    (loop_number),
		.total_runs     (total_runs),
		.overran        (overran),
		.slot_runs      (slot_runs),
		.slot_overruns  (slot_overruns),
		.total_overruns (total_overruns),
		.last           (last)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACK) |-> last && (elapsed_ms == '0))
		else $error("acknowledgement not final or with elapsed time");

	a_dispatch_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DISPATCH) |-> !overran && (slot_runs != '0))
		else $error("dispatch with overrun flag or zero run count");

endmodule

// ===== hdl/pdt_ctrl.sv =====
module pdt_ctrl import pdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	input  pdt_stat_t stat,
	output pdt_ctl_t  ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   emit;
	logic   step_ok;

	assign out_free  = !out_valid_q || out_ready;
	assign step_ok   = !stat.due_now || out_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = ctl.emit_dispatch || ctl.emit_report;

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.load = in_valid;
			end
			ST_DECODE: begin
				case (stat.cmd)
					CMD_TICK:    ctl.tick_setup = 1'b1;
					CMD_RESTART: ctl.restart = 1'b1;
					default:     ;
				endcase
			end
			ST_SCAN: begin
				ctl.emit_dispatch = stat.due_now && out_free;
				ctl.scan_next     = step_ok && !stat.last_idx;
			end
			ST_REPORT: begin
				ctl.emit_report = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					case (stat.cmd)
						CMD_TICK:   state_q <= ST_SCAN;
						CMD_REPORT: state_q <= ST_REPORT;
						default:    state_q <= ST_IDLE;
					endcase
				end
				ST_SCAN: begin
					if (step_ok && stat.last_idx) state_q <= ST_IDLE;
				end
				ST_REPORT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/pdt_dp.sv =====
module pdt_dp import pdt_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [1:0]  slot,
	input  logic [31:0] runtime_us,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  pdt_ctl_t    ctl,
	output pdt_stat_t   stat,
	output logic        kind,
	output logic [1:0]  task_slot,
	output logic [31:0] elapsed_ms,
	output logic [31:0] loop_number,
	output logic [31:0] total_runs,
	output logic        overran,
	output logic [31:0] slot_runs,
	output logic [31:0] slot_overruns,
	output logic [31:0] total_overruns,
	output logic        last
);

	localparam int VISIT = (SLOTS < REG_SLOTS) ? SLOTS : REG_SLOTS;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int VW    = (VISIT > 1) ? $clog2(VISIT) : 1;

	logic [1:0]  cmd_q;
	logic [31:0] now_q;
	logic [1:0]  slot_q;
	logic [31:0] runtime_q;

	logic [3:0]  en_q;
	logic [31:0] intv_q [REG_SLOTS];
	logic [31:0] bud_q  [REG_SLOTS];

	logic [31:0] lrt_q [SLOTS];
	logic [31:0] rc_q  [SLOTS];
	logic [31:0] oc_q  [SLOTS];
	logic [31:0] loop_q;
	logic [31:0] dtot_q;
	logic [31:0] otot_q;
	logic [VISIT-1:0] due_q;
	logic [31:0] elap_q [VISIT];
	logic [VW-1:0] idx_q;

	logic [VISIT-1:0] due_c;
	logic [31:0] elap_c [VISIT];
	logic [SW-1:0] addr;
	logic        in_range;
	logic [31:0] budget;
	logic        over;
	logic [31:0] rc_rd;
	logic [31:0] oc_rd;
	logic [31:0] rc_inc;
	logic [31:0] oc_new;
	logic [31:0] otot_new;
	logic        more_due;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= cmd;
			now_q     <= now_ms;
			slot_q    <= slot;
			runtime_q <= runtime_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			for (int i = 0; i < REG_SLOTS; i++) begin
				intv_q[i] <= '0;
				bud_q[i]  <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE:  en_q <= cfg_data[3:0];
				CFG_INTV_LO: begin
					intv_q[0] <= cfg_data[31:0];
					intv_q[1] <= cfg_data[63:32];
				end
				CFG_INTV_HI: begin
					intv_q[2] <= cfg_data[31:0];
					intv_q[3] <= cfg_data[63:32];
				end
				CFG_BUD_LO: begin
					bud_q[0] <= cfg_data[31:0];
					bud_q[1] <= cfg_data[63:32];
				end
				CFG_BUD_HI: begin
					bud_q[2] <= cfg_data[31:0];
					bud_q[3] <= cfg_data[63:32];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < VISIT; i++) begin
			elap_c[i] = now_q - lrt_q[i];
			due_c[i]  = en_q[i] && ((intv_q[i] == '0) || (elap_c[i] >= intv_q[i]));
		end
	end

	always_comb begin
		more_due = 1'b0;
		for (int j = 0; j < VISIT; j++) begin
			if (due_q[j] && (VW'(j) > idx_q)) more_due = 1'b1;
		end
	end

	assign addr     = ctl.emit_report ? SW'(slot_q) : SW'(idx_q);
	assign in_range = (32'(slot_q) < 32'(SLOTS));
	assign budget   = bud_q[slot_q];
	assign over     = in_range && (budget != '0) && (runtime_q > budget);
	assign rc_rd    = rc_q[addr];
	assign oc_rd    = oc_q[addr];
	assign rc_inc   = rc_rd + 32'd1;
	assign oc_new   = oc_rd + 32'(over);
	assign otot_new = otot_q + 32'(over);

	assign stat.cmd      = cmd_q;
	assign stat.due_now  = due_q[idx_q];
	assign stat.last_idx = (idx_q == VW'(VISIT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				lrt_q[i] <= '0;
				rc_q[i]  <= '0;
				oc_q[i]  <= '0;
			end
			for (int i = 0; i < VISIT; i++) begin
				elap_q[i] <= '0;
			end
			loop_q <= '0;
			dtot_q <= '0;
			otot_q <= '0;
			due_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (ctl.restart) begin
				for (int i = 0; i < SLOTS; i++) begin
					lrt_q[i] <= now_q;
					rc_q[i]  <= '0;
					oc_q[i]  <= '0;
				end
				loop_q <= '0;
				dtot_q <= '0;
				otot_q <= '0;
			end
			if (ctl.tick_setup) begin
				loop_q <= loop_q + 32'd1;
				due_q  <= due_c;
				for (int i = 0; i < VISIT; i++) begin
					elap_q[i] <= elap_c[i];
				end
				idx_q <= '0;
			end
			if (ctl.scan_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.emit_dispatch) begin
				lrt_q[addr] <= now_q;
				rc_q[addr]  <= rc_inc;
				dtot_q      <= dtot_q + 32'd1;
			end
			if (ctl.emit_report) begin
				if (in_range) oc_q[addr] <= oc_new;
				otot_q <= otot_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_dispatch) begin
			kind           <= KIND_DISPATCH;
			task_slot      <= 2'(idx_q);
			elapsed_ms     <= elap_q[idx_q];
			loop_number    <= loop_q;
			total_runs     <= dtot_q;
			overran        <= 1'b0;
			slot_runs      <= rc_inc;
			slot_overruns  <= oc_rd;
			total_overruns <= otot_q;
			last           <= !more_due;
		end else if (ctl.emit_report) begin
			kind           <= KIND_ACK;
			task_slot      <= slot_q;
			elapsed_ms     <= '0;
			loop_number    <= loop_q;
			total_runs     <= dtot_q;
			overran        <= over;
			slot_runs      <= in_range ? rc_rd : '0;
			slot_overruns  <= in_range ? oc_new : '0;
			total_overruns <= otot_new;
			last           <= 1'b1;
		end
	end

endmodule
